FILE: rtl/pcd_pkg.sv
// Shared constants for the path curvature and curvature-rate datapath.
`timescale 1ns / 1ps

package pcd_pkg;

    // Input sample width (signed Q8.16) and result width (signed Q12.20).
    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    // Bits of the root found by each chain, one cell per bit.
    localparam int QW = 32;

    // Twice the 36-bit shift from Q16*Q16 products to a Q20 result.
    localparam int FRAC_SHIFT = 72;

    // Limb width of the pipelined wide multiplier.
    localparam int LIMB_W = 24;

    // Cycles from an accepted command to its result strobe.
    localparam int PIPE_LAT = 48;

    // Clamp values of a saturated result.
    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

FILE: rtl/pcd_wmul.sv
// Four-stage pipelined wide unsigned multiplier built from limb products.
`timescale 1ns / 1ps

module pcd_wmul #(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_a,
    input  logic [BW-1:0]      i_b,
    output logic [AW+BW-1:0]   o_p
);
    import pcd_pkg::*;

    localparam int LA = (AW + LIMB_W - 1) / LIMB_W;
    localparam int LB = (BW + LIMB_W - 1) / LIMB_W;
    localparam int NC = LA + LB - 1;
    localparam int CW = 2 * LIMB_W + 4;
    localparam int PW = (LA + LB + 1) * LIMB_W;

    logic [LA*LIMB_W-1:0] a_pad;
    logic [LB*LIMB_W-1:0] b_pad;
    logic [2*LIMB_W-1:0]  r_pp [LA][LB];
    logic [CW-1:0]        n_col [NC];
    logic [CW-1:0]        r_col [NC];
    logic [PW-1:0]        ev_lo, ev_hi, od_lo, od_hi;
    logic [PW-1:0]        r_ev, r_od, r_p;

    assign a_pad = (LA*LIMB_W)'(i_a);
    assign b_pad = (LB*LIMB_W)'(i_b);

    // Stage one: every limb pair multiplied on its own.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LA; i++) begin
            for (int j = 0; j < LB; j++) begin
                r_pp[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
            end
        end
    end

    // Stage two: products of equal weight are summed into columns.
    always_comb begin
        for (int s = 0; s < NC; s++) begin
            n_col[s] = '0;
        end
        for (int i = 0; i < LA; i++) begin
            for (int j = 0; j < LB; j++) begin
                n_col[i+j] = n_col[i+j] + CW'(r_pp[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    // Stage three: columns of one parity do not overlap, so they are packed
    // side by side, the narrow carry parts in a word of their own.
    always_comb begin
        ev_lo = '0;
        ev_hi = '0;
        od_lo = '0;
        od_hi = '0;
        for (int s = 0; s < NC; s += 2) begin
            ev_lo = ev_lo | (PW'(r_col[s][2*LIMB_W-1:0]) << (s*LIMB_W));
            ev_hi = ev_hi | (PW'(r_col[s][CW-1:2*LIMB_W]) << (s*LIMB_W + 2*LIMB_W));
        end
        for (int s = 1; s < NC; s += 2) begin
            od_lo = od_lo | (PW'(r_col[s][2*LIMB_W-1:0]) << (s*LIMB_W));
            od_hi = od_hi | (PW'(r_col[s][CW-1:2*LIMB_W]) << (s*LIMB_W + 2*LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= ev_lo + ev_hi;
        r_od <= od_lo + od_hi;
    end

    // Stage four: the two halves are brought together.
    always_ff @(posedge i_clk) begin
        r_p <= r_ev + r_od;
    end

    assign o_p = r_p[AW+BW-1:0];

endmodule

FILE: rtl/pcd_delay.sv
// Fixed-length shift line that keeps side data aligned with the datapath.
`timescale 1ns / 1ps

module pcd_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

FILE: rtl/pcd_sqrt_cell.sv
// One cell of the root chain: decides one bit of floor(sqrt(N / D)).
`timescale 1ns / 1ps

module pcd_sqrt_cell #(
    parameter int DW  = 144,
    parameter int RW  = 168,
    parameter int BIT = 31
) (
    input  logic                        i_clk,
    input  logic [DW-1:0]               i_d,
    input  logic [RW-1:0]               i_r,
    input  logic [DW+pcd_pkg::QW-1:0]   i_p,
    input  logic [pcd_pkg::QW-1:0]      i_q,
    output logic [DW-1:0]               o_d,
    output logic [RW-1:0]               o_r,
    output logic [DW+pcd_pkg::QW-1:0]   o_p,
    output logic [pcd_pkg::QW-1:0]      o_q
);
    import pcd_pkg::*;

    localparam int XW = DW + 2 * QW + 2;
    localparam int PW = DW + QW;

    logic [XW-1:0] t_try;
    logic          take;
    logic [DW-1:0] r_d;
    logic [RW-1:0] r_r;
    logic [PW-1:0] r_p;
    logic [QW-1:0] r_q;

    // Residual R = N - q*q*D and P = q*D are kept, so setting bit k costs
    // D * 2^k * (2q + 2^k) = (P << k+1) + (D << 2k): shifts and one add.
    assign t_try = (XW'(i_p) << (BIT + 1)) + (XW'(i_d) << (2 * BIT));
    assign take  = XW'(i_r) >= t_try;

    always_ff @(posedge i_clk) begin
        r_d <= i_d;
        if (take) begin
            r_r <= RW'(XW'(i_r) - t_try);
            r_p <= i_p + (PW'(i_d) << BIT);
            r_q <= i_q | (QW'(1) << BIT);
        end else begin
            r_r <= i_r;
            r_p <= i_p;
            r_q <= i_q;
        end
    end

    assign o_d = r_d;
    assign o_r = r_r;
    assign o_p = r_p;
    assign o_q = r_q;

endmodule

FILE: rtl/path_curvature_and_derivative.sv
// Top level: curvature and curvature rate of a planar path point.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                   Beat contents
//  command   in         start high and busy low     i_first_*, i_second_*, i_third_*
//  result    out        o_strobe, one cycle         o_curvature, o_curvature_rate,
//                                                   o_degenerate, o_saturated
//
//  A command is taken in every cycle in which busy is low; each result strobes
//  after its command has passed the multiplier front end, the two 32-cell root
//  chains that run side by side, one bit per cell, and the output register.
//  busy is high only during reset and in the cycle after it.
//  The synchronous reset clears the strobe pipeline; data registers are not reset.
//  The receiver cannot stall, so there is no back-pressure anywhere.

module path_curvature_and_derivative (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_first_x,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_first_y,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_second_x,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_second_y,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_third_x,
    input  logic signed [pcd_pkg::IN_W-1:0]   i_third_y,
    output logic                              o_strobe,
    output logic signed [pcd_pkg::OUT_W-1:0]  o_curvature,
    output logic signed [pcd_pkg::OUT_W-1:0]  o_curvature_rate,
    output logic                              o_degenerate,
    output logic                              o_saturated
);
    import pcd_pkg::*;

    // Widths of the exact integer quantities.
    localparam int PR_W  = 2 * IN_W;          // one product of two inputs
    localparam int MAG_W = 2 * IN_W;          // |c|, |a|, |d| and b
    localparam int SUM_W = 2 * IN_W + 1;      // signed c, a, d
    localparam int SQ_W  = 2 * MAG_W;         // b^2, c^2, |a*b|, |c*d|
    localparam int CD3_W = SQ_W + 2;          // 3*|c*d|
    localparam int DF_W  = SQ_W + 4;          // signed a*b - 3*c*d
    localparam int E_W   = SQ_W + 1;          // its magnitude
    localparam int B3_W  = 3 * MAG_W;
    localparam int B5_W  = 5 * MAG_W;
    localparam int N1_W  = SQ_W + FRAC_SHIFT;
    localparam int N2_W  = 2 * E_W + FRAC_SHIFT;
    localparam int P1_W  = B3_W + QW;
    localparam int P2_W  = B5_W + QW;

    // Control.
    logic                r_alive;
    logic [PIPE_LAT-1:0] r_vld;
    logic                accept;

    // Stage one: the eight input products.
    logic signed [PR_W-1:0] r_x1x1, r_y1y1, r_x1y2, r_y1x2, r_x1y3, r_y1x3, r_x1x2, r_y1y2;
    logic                   r_deg1;

    // Stage two: b, c, a and d.
    logic [MAG_W-1:0]        r_b;
    logic signed [SUM_W-1:0] r_c, r_a, r_d;
    logic                    r_deg2;

    // Stage three: magnitudes and signs.
    logic [MAG_W-1:0] r_bm, r_cm, r_am, r_dm;
    logic             r_sa, r_sc, r_sd, r_deg3;

    // Multiplier outputs and alignment lines.
    logic [SQ_W-1:0]   m_b2, m_c2, m_ab, m_cd;
    logic [MAG_W-1:0]  b_d4;
    logic [SQ_W-1:0]   b2_d4, c2_d8;
    logic [B3_W-1:0]   m_b3, b3_d4;
    logic [B5_W-1:0]   m_b5;
    logic [2*E_W-1:0]  m_e2;
    logic [2*E_W-1:0]  r_e2;
    logic [1:0]        sgn_d4;
    logic [1:0]        side_d12;
    logic              neg2_d5;
    logic [2:0]        side_d32;

    // Numerator of the rate.
    logic [SQ_W-1:0]        r_ab;
    logic [CD3_W-1:0]       r_cd3;
    logic                   r_sab, r_scd;
    logic signed [DF_W-1:0] ab_s, cd_s;
    logic signed [DF_W-1:0] r_diff;
    logic [E_W-1:0]         r_e;
    logic                   r_neg2;

    // Root chains.
    logic [B3_W-1:0] w_d1 [0:QW];
    logic [N1_W-1:0] w_r1 [0:QW];
    logic [P1_W-1:0] w_p1 [0:QW];
    logic [QW-1:0]   w_q1 [0:QW];
    logic [B5_W-1:0] w_d2 [0:QW];
    logic [N2_W-1:0] w_r2 [0:QW];
    logic [P2_W-1:0] w_p2 [0:QW];
    logic [QW-1:0]   w_q2 [0:QW];

    // Result stage.
    logic [OUT_W:0] fin1, fin2;

    // busy covers reset and the first cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else begin
            r_alive <= 1'b1;
        end
    end

    assign busy   = ~r_alive;
    assign accept = start & ~busy;

    // The data path runs free; a shift line of valid bits marks which beats
    // leaving it belong to accepted commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept};
        end
    end

    assign o_strobe = r_vld[PIPE_LAT-1];

    // Stage one: one 24 by 24 product per multiplier.
    always_ff @(posedge i_clk) begin
        r_x1x1 <= i_first_x * i_first_x;
        r_y1y1 <= i_first_y * i_first_y;
        r_x1y2 <= i_first_x * i_second_y;
        r_y1x2 <= i_first_y * i_second_x;
        r_x1y3 <= i_first_x * i_third_y;
        r_y1x3 <= i_first_y * i_third_x;
        r_x1x2 <= i_first_x * i_second_x;
        r_y1y2 <= i_first_y * i_second_y;
        r_deg1 <= (i_first_x == '0) && (i_first_y == '0);
    end

    // Stage two: b = x'^2 + y'^2 is never negative and fits in 48 bits.
    always_ff @(posedge i_clk) begin
        r_b    <= MAG_W'(r_x1x1) + MAG_W'(r_y1y1);
        r_c    <= SUM_W'(r_x1y2) - SUM_W'(r_y1x2);
        r_a    <= SUM_W'(r_x1y3) - SUM_W'(r_y1x3);
        r_d    <= SUM_W'(r_x1x2) + SUM_W'(r_y1y2);
        r_deg2 <= r_deg1;
    end

    // Stage three: the wide products work on magnitudes; signs go alongside.
    always_ff @(posedge i_clk) begin
        r_bm   <= r_b;
        r_cm   <= r_c[SUM_W-1] ? MAG_W'(-r_c) : MAG_W'(r_c);
        r_am   <= r_a[SUM_W-1] ? MAG_W'(-r_a) : MAG_W'(r_a);
        r_dm   <= r_d[SUM_W-1] ? MAG_W'(-r_d) : MAG_W'(r_d);
        r_sc   <= r_c[SUM_W-1];
        r_sa   <= r_a[SUM_W-1];
        r_sd   <= r_d[SUM_W-1];
        r_deg3 <= r_deg2;
    end

    pcd_wmul #(.AW(MAG_W), .BW(MAG_W)) u_mul_b2 (
        .i_clk (i_clk), .i_a (r_bm), .i_b (r_bm), .o_p (m_b2)
    );
    pcd_wmul #(.AW(MAG_W), .BW(MAG_W)) u_mul_c2 (
        .i_clk (i_clk), .i_a (r_cm), .i_b (r_cm), .o_p (m_c2)
    );
    pcd_wmul #(.AW(MAG_W), .BW(MAG_W)) u_mul_ab (
        .i_clk (i_clk), .i_a (r_am), .i_b (r_bm), .o_p (m_ab)
    );
    pcd_wmul #(.AW(MAG_W), .BW(MAG_W)) u_mul_cd (
        .i_clk (i_clk), .i_a (r_cm), .i_b (r_dm), .o_p (m_cd)
    );

    // Powers of b for the two denominators, b^3 and b^5.
    pcd_delay #(.WIDTH(MAG_W), .DEPTH(4)) u_dly_b (
        .i_clk (i_clk), .i_d (r_bm), .o_q (b_d4)
    );
    pcd_wmul #(.AW(SQ_W), .BW(MAG_W)) u_mul_b3 (
        .i_clk (i_clk), .i_a (m_b2), .i_b (b_d4), .o_p (m_b3)
    );
    pcd_delay #(.WIDTH(SQ_W), .DEPTH(4)) u_dly_b2 (
        .i_clk (i_clk), .i_d (m_b2), .o_q (b2_d4)
    );
    pcd_wmul #(.AW(B3_W), .BW(SQ_W)) u_mul_b5 (
        .i_clk (i_clk), .i_a (m_b3), .i_b (b2_d4), .o_p (m_b5)
    );

    // Sign of a*b is that of a (b is positive), sign of c*d is sc ^ sd.
    pcd_delay #(.WIDTH(2), .DEPTH(4)) u_dly_sgn (
        .i_clk (i_clk), .i_d ({r_sa, r_sc ^ r_sd}), .o_q (sgn_d4)
    );

    always_ff @(posedge i_clk) begin
        r_ab  <= m_ab;
        r_cd3 <= CD3_W'(m_cd) + (CD3_W'(m_cd) << 1);
        r_sab <= sgn_d4[1];
        r_scd <= sgn_d4[0];
    end

    assign ab_s = r_sab ? -DF_W'(r_ab)  : DF_W'(r_ab);
    assign cd_s = r_scd ? -DF_W'(r_cd3) : DF_W'(r_cd3);

    always_ff @(posedge i_clk) begin
        r_diff <= ab_s - cd_s;
    end

    always_ff @(posedge i_clk) begin
        r_e    <= r_diff[DF_W-1] ? E_W'(-r_diff) : E_W'(r_diff);
        r_neg2 <= r_diff[DF_W-1];
    end

    pcd_wmul #(.AW(E_W), .BW(E_W)) u_mul_e2 (
        .i_clk (i_clk), .i_a (r_e), .i_b (r_e), .o_p (m_e2)
    );

    always_ff @(posedge i_clk) begin
        r_e2 <= m_e2;
    end

    // Line everything up where both chains start.
    pcd_delay #(.WIDTH(SQ_W), .DEPTH(8)) u_dly_c2 (
        .i_clk (i_clk), .i_d (m_c2), .o_q (c2_d8)
    );
    pcd_delay #(.WIDTH(B3_W), .DEPTH(4)) u_dly_b3 (
        .i_clk (i_clk), .i_d (m_b3), .o_q (b3_d4)
    );
    pcd_delay #(.WIDTH(2), .DEPTH(12)) u_dly_side (
        .i_clk (i_clk), .i_d ({r_deg3, r_sc}), .o_q (side_d12)
    );
    pcd_delay #(.WIDTH(1), .DEPTH(5)) u_dly_neg2 (
        .i_clk (i_clk), .i_d (r_neg2), .o_q (neg2_d5)
    );

    // Curvature chain finds floor(sqrt(c^2 * 2^72 / b^3)), the rate chain
    // floor(sqrt(e^2 * 2^72 / b^5)); both exact, one bit per cell, top bit first.
    assign w_d1[0] = b3_d4;
    assign w_r1[0] = {c2_d8, {FRAC_SHIFT{1'b0}}};
    assign w_p1[0] = '0;
    assign w_q1[0] = '0;
    assign w_d2[0] = m_b5;
    assign w_r2[0] = {r_e2, {FRAC_SHIFT{1'b0}}};
    assign w_p2[0] = '0;
    assign w_q2[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_chain
        pcd_sqrt_cell #(.DW(B3_W), .RW(N1_W), .BIT(QW - 1 - g)) u_cell1 (
            .i_clk (i_clk),
            .i_d   (w_d1[g]),   .i_r (w_r1[g]),   .i_p (w_p1[g]),   .i_q (w_q1[g]),
            .o_d   (w_d1[g+1]), .o_r (w_r1[g+1]), .o_p (w_p1[g+1]), .o_q (w_q1[g+1])
        );
        pcd_sqrt_cell #(.DW(B5_W), .RW(N2_W), .BIT(QW - 1 - g)) u_cell2 (
            .i_clk (i_clk),
            .i_d   (w_d2[g]),   .i_r (w_r2[g]),   .i_p (w_p2[g]),   .i_q (w_q2[g]),
            .o_d   (w_d2[g+1]), .o_r (w_r2[g+1]), .o_p (w_p2[g+1]), .o_q (w_q2[g+1])
        );
    end

    pcd_delay #(.WIDTH(3), .DEPTH(QW)) u_dly_chain (
        .i_clk (i_clk), .i_d ({side_d12, neg2_d5}), .o_q (side_d32)
    );

    // Apply the sign and clamp. A root with its top bit set is at least 2^31:
    // a positive result saturates, a negative one saturates only above 2^31.
    function automatic logic [OUT_W:0] fn_finish(input logic [QW-1:0] q, input logic neg);
        logic [OUT_W-1:0] v;
        logic             s;
        if (!neg) begin
            if (q[QW-1]) begin
                v = SAT_POS;
                s = 1'b1;
            end else begin
                v = OUT_W'(q);
                s = 1'b0;
            end
        end else begin
            if (q[QW-1]) begin
                v = SAT_NEG;
                s = |q[QW-2:0];
            end else begin
                v = OUT_W'(-q);
                s = 1'b0;
            end
        end
        return {s, v};
    endfunction

    assign fin1 = fn_finish(w_q1[QW], side_d32[1]);
    assign fin2 = fn_finish(w_q2[QW], side_d32[0]);

    // A point with no first derivative has no curvature: zero out, flag it.
    always_ff @(posedge i_clk) begin
        if (side_d32[2]) begin
            o_curvature      <= '0;
            o_curvature_rate <= '0;
            o_degenerate     <= 1'b1;
            o_saturated      <= 1'b0;
        end else begin
            o_curvature      <= fin1[OUT_W-1:0];
            o_curvature_rate <= fin2[OUT_W-1:0];
            o_degenerate     <= 1'b0;
            o_saturated      <= fin1[OUT_W] | fin2[OUT_W];
        end
    end

endmodule

FILE: rtl/pcd_checker.sv
// Port-level checks for the curvature block, bound to the top level.
`timescale 1ns / 1ps

module pcd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [pcd_pkg::IN_W-1:0]   i_first_x,
    input logic signed [pcd_pkg::IN_W-1:0]   i_first_y,
    input logic signed [pcd_pkg::IN_W-1:0]   i_second_x,
    input logic signed [pcd_pkg::IN_W-1:0]   i_second_y,
    input logic signed [pcd_pkg::IN_W-1:0]   i_third_x,
    input logic signed [pcd_pkg::IN_W-1:0]   i_third_y,
    input logic                              o_strobe,
    input logic signed [pcd_pkg::OUT_W-1:0]  o_curvature,
    input logic signed [pcd_pkg::OUT_W-1:0]  o_curvature_rate,
    input logic                              o_degenerate,
    input logic                              o_saturated
);
    import pcd_pkg::*;

    // Every accepted beat produces exactly one result, a fixed time later.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_LAT o_strobe)
        else $error("accepted beat gave no result");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without a command");

    // The degenerate flag follows the first derivatives of its own command.
    a_deg_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_degenerate == $past(i_first_x == '0 && i_first_y == '0, PIPE_LAT))
        else $error("degenerate flag does not match the command");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_degenerate |->
            o_curvature == '0 && o_curvature_rate == '0 && !o_saturated)
        else $error("degenerate result not cleared");

endmodule

bind path_curvature_and_derivative pcd_checker u_pcd_checker (.*);
